// File: hw/rtl/rrsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrsp_pkg;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_CLEAR     = 3'd1,
    CMD_ADD       = 3'd2,
    CMD_NEXT_GOOD = 3'd3,
    CMD_MARK_BAD  = 3'd4,
    CMD_MARK_GOOD = 3'd5,
    CMD_RESET_Q   = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ALL_BAD   = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned TicksW = 32;
  localparam int unsigned CountW = 5;

  typedef struct packed {
    logic [2:0]      command;
    logic [KeyW-1:0] server_key;
  } in_beat_t;

  typedef struct packed {
    status_e           status;
    logic [KeyW-1:0]   picked_key;
    logic              picked_valid;
    logic [CountW-1:0] entry_count;
  } out_beat_t;

endpackage

`default_nettype wire

// File: hw/rtl/rrsp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rrsp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/round_robin_server_picker_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Round-robin server picker with timed quarantine.
// Commands arrive as beats on the in channel (in_valid_i, in_stall_o, in_data_i) and each
// command produces exactly one result beat on the out channel (out_valid_o, out_stall_i,
// out_data_o). A beat moves at a rising edge where valid is high and stall is low.
// Clear, add, the quarantine reset, unassigned codes and a pick on an empty table pass
// through the S_IMM state to the result register. Tick, mark bad, mark good and pick walk
// the table one entry per cycle through the key and countdown memories, whose read port
// is registered, so each entry is checked when its read data returns.
// One command is worked on at a time; the next is accepted in the cycle after the previous
// result sits in the output register, even if the receiver has not yet taken it.
// If the receiver stalls while a result is still held, the walk freezes on its last step
// until the output register frees up.
// Reset empties the table, zeroes the rotating pointer, marks all entries good and loads
// bad_memory_ticks with 300. No clearing pass is needed: valid bits stand for zero
// countdowns. bad_memory_ticks is written through the APB port at address 0.
// An entry is bad exactly while its countdown is nonzero, so only the countdown is stored.

module round_robin_server_picker_unit #(
  parameter int unsigned MAX_SERVERS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire rrsp_pkg::in_beat_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output rrsp_pkg::out_beat_t     out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [0:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);
  import rrsp_pkg::*;

  localparam int unsigned AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int unsigned CW = $clog2(MAX_SERVERS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_IMM  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [2:0]             cmd_q, cmd_d;
  logic [KeyW-1:0]        key_q, key_d;
  logic [CW-1:0]          count_q, count_d;
  logic [AW-1:0]          ptr_q, ptr_d;
  logic [AW-1:0]          addr_q, addr_d;
  logic [AW-1:0]          paddr_q, paddr_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   pend_q, pend_d;
  logic [MAX_SERVERS-1:0] qv_q, qv_d;
  logic [TicksW-1:0]      ticks_q;
  out_beat_t              out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  logic              key_we, q_we, rd_en;
  logic [AW-1:0]     key_waddr, q_waddr, raddr;
  logic [TicksW-1:0] q_wdata;
  logic [KeyW-1:0]   key_rdata;
  logic [TicksW-1:0] q_rdata, qval;
  logic              fin_ok, hit, done;

  rrsp_ram #(.Width(KeyW), .Depth(MAX_SERVERS)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_q),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (key_rdata)
  );

  rrsp_ram #(.Width(TicksW), .Depth(MAX_SERVERS)) u_quar_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (q_rdata)
  );

  // Configuration port: one register, always ready.
  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? ticks_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= 32'd300;
    end else if (psel && penable && pwrite && (paddr == 1'b0)) begin
      ticks_q <= pwdata;
    end
  end

  // Next address in round-robin order within the filled part of the table.
  function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] a, input logic [CW-1:0] n);
    logic [CW-1:0] s;
    s = CW'(a) + CW'(1);
    return (s == n) ? '0 : AW'(s);
  endfunction

  // An entry whose valid bit is clear has a zero countdown.
  assign qval   = qv_q[paddr_q] ? q_rdata : '0;
  assign fin_ok = !out_valid_q || !out_stall_i;

  always_comb begin
    hit = 1'b0;
    if (pend_q) begin
      if (cmd_q == CMD_NEXT_GOOD) begin
        hit = (qval == '0);
      end else if (cmd_q == CMD_MARK_BAD || cmd_q == CMD_MARK_GOOD) begin
        hit = (key_rdata == key_q);
      end
    end
    done = hit || (cnt_q == count_q);
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    addr_d      = addr_q;
    paddr_d     = paddr_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    qv_d        = qv_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    key_we      = 1'b0;
    key_waddr   = count_q[AW-1:0];
    q_we        = 1'b0;
    q_waddr     = paddr_q;
    q_wdata     = '0;
    rd_en       = 1'b0;
    raddr       = addr_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d  = in_data_i.command;
          key_d  = in_data_i.server_key;
          addr_d = '0;
          cnt_d  = '0;
          pend_d = 1'b0;
          if (in_data_i.command == CMD_TICK || in_data_i.command == CMD_MARK_BAD ||
              in_data_i.command == CMD_MARK_GOOD) begin
            state_d = S_SCAN;
          end else if (in_data_i.command == CMD_NEXT_GOOD && count_q != '0) begin
            addr_d  = ptr_q;
            state_d = S_SCAN;
          end else begin
            state_d = S_IMM;
          end
        end
      end

      S_IMM: begin
        if (fin_ok) begin
          out_d.status       = ST_OK;
          out_d.picked_key   = '0;
          out_d.picked_valid = 1'b0;
          unique case (cmd_q)
            CMD_CLEAR: begin
              count_d = '0;
              ptr_d   = '0;
            end
            CMD_ADD: begin
              if (count_q == CW'(MAX_SERVERS)) begin
                out_d.status = ST_FULL;
              end else begin
                key_we                  = 1'b1;
                qv_d[count_q[AW-1:0]]   = 1'b0;
                count_d                 = count_q + CW'(1);
              end
            end
            CMD_NEXT_GOOD: out_d.status = ST_EMPTY;
            CMD_RESET_Q:   qv_d = '0;
            default: ;
          endcase
          out_d.entry_count = CountW'(count_d);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end

      S_SCAN: begin
        if (done) begin
          if (fin_ok) begin
            out_d.status       = ST_OK;
            out_d.picked_key   = '0;
            out_d.picked_valid = 1'b0;
            out_d.entry_count  = CountW'(count_q);
            unique case (cmd_q)
              CMD_TICK: begin
                if (pend_q && qval != '0) begin
                  q_we          = 1'b1;
                  q_wdata       = qval - TicksW'(1);
                  qv_d[paddr_q] = 1'b1;
                end
              end
              CMD_NEXT_GOOD: begin
                if (hit) begin
                  ptr_d              = wrap_next(paddr_q, count_q);
                  out_d.picked_key   = key_rdata;
                  out_d.picked_valid = 1'b1;
                end else begin
                  out_d.status = ST_ALL_BAD;
                end
              end
              CMD_MARK_BAD: begin
                if (hit) begin
                  q_we          = 1'b1;
                  q_wdata       = ticks_q;
                  qv_d[paddr_q] = 1'b1;
                end else begin
                  out_d.status = ST_NOT_FOUND;
                end
              end
              CMD_MARK_GOOD: begin
                if (hit) begin
                  qv_d[paddr_q] = 1'b0;
                end else begin
                  out_d.status = ST_NOT_FOUND;
                end
              end
              default: ;
            endcase
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
        end else begin
          // Tick writes back the decremented countdown of the entry read last cycle.
          if (cmd_q == CMD_TICK && pend_q && qval != '0) begin
            q_we          = 1'b1;
            q_wdata       = qval - TicksW'(1);
            qv_d[paddr_q] = 1'b1;
          end
          rd_en   = 1'b1;
          paddr_d = addr_q;
          addr_d  = wrap_next(addr_q, count_q);
          cnt_d   = cnt_q + CW'(1);
          pend_d  = 1'b1;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      qv_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      qv_q        <= qv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    key_q   <= key_d;
    addr_q  <= addr_d;
    paddr_q <= paddr_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: test/tb_round_robin_server_picker_unit.sv
`timescale 1ns / 1ps

module tb_round_robin_server_picker_unit;
  import rrsp_pkg::*;

  localparam int unsigned NumSlots = 16;
  // Command code seven is not assigned; the block must treat it as a no-op.
  localparam logic [2:0] CmdUnused = 3'd7;
  // Cycles with no beat on either channel before the run is declared hung.
  localparam int unsigned StuckLimit = 4000;
  // Drain margin: a full table walk plus overhead, taken with slack.
  localparam int unsigned DrainCycles = 25;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_beat_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_beat_t out_data_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [0:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  round_robin_server_picker_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Shadow copy of the picker's table, kept in step with every accepted beat.
  logic [31:0] shadow_keys [NumSlots];
  bit          shadow_bad  [NumSlots];
  logic [31:0] shadow_left [NumSlots];
  int unsigned shadow_count;
  int unsigned shadow_ptr;
  logic [31:0] shadow_ticks;

  // Results still owed by the block, oldest first.
  out_beat_t pending_results[$];

  int unsigned mismatches;
  int unsigned stuck_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hung;

  // Applies one command to the shadow table and returns the result it must produce.
  function automatic out_beat_t apply_command(logic [2:0] cmd, logic [31:0] key);
    out_beat_t r;
    int hit;
    int unsigned idx;
    r.status       = ST_OK;
    r.picked_key   = '0;
    r.picked_valid = 1'b0;
    hit = -1;
    case (cmd)
      CMD_TICK: begin
        for (int i = 0; i < NumSlots; i++) begin
          if (shadow_left[i] != 0) shadow_left[i] = shadow_left[i] - 1;
        end
      end
      CMD_CLEAR: begin
        shadow_count = 0;
        shadow_ptr   = 0;
      end
      CMD_ADD: begin
        if (shadow_count >= NumSlots) begin
          r.status = ST_FULL;
        end else begin
          shadow_keys[shadow_count] = key;
          shadow_bad[shadow_count]  = 1'b0;
          shadow_left[shadow_count] = '0;
          shadow_count++;
        end
      end
      CMD_NEXT_GOOD: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // Quarantine that has run out is lifted before the scan.
          for (int i = 0; i < shadow_count; i++) begin
            if (shadow_bad[i] && shadow_left[i] == 0) shadow_bad[i] = 1'b0;
          end
          r.status = ST_ALL_BAD;
          for (int i = 0; i < shadow_count; i++) begin
            idx = (shadow_ptr % shadow_count + i) % shadow_count;
            if (!shadow_bad[idx]) begin
              shadow_ptr     = (idx + 1) % shadow_count;
              r.picked_key   = shadow_keys[idx];
              r.picked_valid = 1'b1;
              r.status       = ST_OK;
              break;
            end
          end
        end
      end
      CMD_MARK_BAD, CMD_MARK_GOOD: begin
        // Only the lowest matching entry is touched when keys repeat.
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_keys[i] == key) begin
            hit = i;
            break;
          end
        end
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else if (cmd == CMD_MARK_BAD) begin
          shadow_bad[hit]  = 1'b1;
          shadow_left[hit] = shadow_ticks;
        end else begin
          shadow_bad[hit]  = 1'b0;
          shadow_left[hit] = '0;
        end
      end
      CMD_RESET_Q: begin
        for (int i = 0; i < NumSlots; i++) begin
          shadow_bad[i]  = 1'b0;
          shadow_left[i] = '0;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = shadow_count[4:0];
    return r;
  endfunction

  // Offers one command beat and holds it until the block takes it. Called right after
  // a rising edge; returns right after the edge at which the beat moved.
  task automatic send_command(logic [2:0] cmd, logic [31:0] key, bit typed,
                              out_beat_t typed_result);
    out_beat_t predicted;
    in_valid_i           <= 1'b1;
    in_data_i.command    <= cmd;
    in_data_i.server_key <= key;
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) begin
        predicted = apply_command(cmd, key);
        pending_results.insert(pending_results.size(), typed ? typed_result : predicted);
        @(posedge clk_i);
        break;
      end
      @(posedge clk_i);
    end
  endtask

  task automatic sender_gap();
    int unsigned gap;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(6, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    while (pending_results.size() != 0 && !hung) @(posedge clk_i);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_ticks(logic [31:0] value);
    in_valid_i <= 1'b0;
    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= '0;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_ticks = value;
    @(posedge clk_i);
  endtask

  // Random commands lean on adds and picks so the table fills, rotates and goes bad.
  task automatic random_command(output logic [2:0] cmd, output logic [31:0] key);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 24)      cmd = CMD_ADD;
    else if (roll < 50) cmd = CMD_NEXT_GOOD;
    else if (roll < 66) cmd = CMD_MARK_BAD;
    else if (roll < 74) cmd = CMD_MARK_GOOD;
    else if (roll < 89) cmd = CMD_TICK;
    else if (roll < 93) cmd = CMD_CLEAR;
    else if (roll < 97) cmd = CMD_RESET_Q;
    else                cmd = CmdUnused;
    roll = $urandom_range(9);
    if (roll < 2)       key = $urandom();
    else if (roll == 2) key = '1;
    else if (roll == 3) key = '0;
    else                key = 32'h1000_0000 + $urandom_range(5);
  endtask

  task automatic random_phase(logic [31:0] ticks, int unsigned items, int unsigned s_pct,
                              int unsigned r_pct, bit hold_off);
    logic [2:0] cmd;
    logic [31:0] key;
    out_beat_t unused;
    unused = '0;
    write_ticks(ticks);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int n = 0; n < items && !hung; n++) begin
      if (hold_off && n == items / 2) begin
        in_valid_i <= 1'b0;
        wait_for_results();
      end
      random_command(cmd, key);
      send_command(cmd, key, 1'b0, unused);
      sender_gap();
    end
    in_valid_i <= 1'b0;
  endtask

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] key;
    int unsigned reps;
    bit          typed;
    status_e     status;
    logic [31:0] picked_key;
    logic        picked_valid;
    logic [4:0]  entry_count;
  } stim_row_t;

  localparam int unsigned NumRows = 20;
  stim_row_t directed_rows [NumRows];

  initial begin
    out_beat_t typed_result;
    directed_rows = '{
      '{CMD_NEXT_GOOD, 32'h0,         1,  1, ST_EMPTY,     32'h0,         1'b0, 5'd0},
      '{CMD_MARK_BAD,  32'h5,         1,  1, ST_NOT_FOUND, 32'h0,         1'b0, 5'd0},
      '{CMD_ADD,       32'h0,         1,  1, ST_OK,        32'h0,         1'b0, 5'd1},
      '{CMD_ADD,       32'hFFFF_FFFF, 1,  1, ST_OK,        32'h0,         1'b0, 5'd2},
      '{CMD_NEXT_GOOD, 32'h0,         1,  1, ST_OK,        32'h0,         1'b1, 5'd2},
      '{CMD_NEXT_GOOD, 32'h0,         1,  1, ST_OK,        32'hFFFF_FFFF, 1'b1, 5'd2},
      '{CMD_MARK_BAD,  32'hFFFF_FFFF, 1,  0, ST_OK,        32'h0,         1'b0, 5'd0},
      '{CMD_NEXT_GOOD, 32'h0,         1,  0, ST_OK,        32'h0,         1'b0, 5'd0},
      '{CMD_MARK_BAD,  32'h0,         1,  0, ST_OK,        32'h0,         1'b0, 5'd0},
      '{CMD_NEXT_GOOD, 32'h0,         1,  1, ST_ALL_BAD,   32'h0,         1'b0, 5'd2},
      '{CMD_TICK,      32'h0,         1,  0, ST_OK,        32'h0,         1'b0, 5'd0},
      '{CMD_MARK_GOOD, 32'h0,         1,  0, ST_OK,        32'h0,         1'b0, 5'd0},
      '{CMD_NEXT_GOOD, 32'h0,         1,  0, ST_OK,        32'h0,         1'b0, 5'd0},
      '{CMD_RESET_Q,   32'h0,         1,  0, ST_OK,        32'h0,         1'b0, 5'd0},
      '{CmdUnused,     32'hA5A5_5A5A, 1,  0, ST_OK,        32'h0,         1'b0, 5'd0},
      '{CMD_ADD,       32'h0,         1,  0, ST_OK,        32'h0,         1'b0, 5'd0},
      '{CMD_MARK_BAD,  32'h0,         1,  0, ST_OK,        32'h0,         1'b0, 5'd0},
      '{CMD_CLEAR,     32'h0,         1,  1, ST_OK,        32'h0,         1'b0, 5'd0},
      '{CMD_ADD,       32'h7000_0000, 16, 0, ST_OK,        32'h0,         1'b0, 5'd0},
      '{CMD_ADD,       32'h1234_5678, 1,  1, ST_FULL,      32'h0,         1'b0, 5'd16}
    };

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_stall_i   = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    mismatches    = 0;
    hung          = 1'b0;
    shadow_count  = 0;
    shadow_ptr    = 0;
    shadow_ticks  = 32'd300;
    for (int i = 0; i < NumSlots; i++) begin
      shadow_keys[i] = '0;
      shadow_bad[i]  = 1'b0;
      shadow_left[i] = '0;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part runs with the reset quarantine length and no idling.
    foreach (directed_rows[r]) begin
      typed_result.status       = directed_rows[r].status;
      typed_result.picked_key   = directed_rows[r].picked_key;
      typed_result.picked_valid = directed_rows[r].picked_valid;
      typed_result.entry_count  = directed_rows[r].entry_count;
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        send_command(directed_rows[r].cmd, directed_rows[r].key + k,
                     directed_rows[r].typed, typed_result);
      end
    end
    // The full table is picked once with every slot good, then the random phases start.
    send_command(CMD_NEXT_GOOD, '0, 1'b0, typed_result);

    // A zero quarantine lets a bad entry come back at the very next pick.
    random_phase(32'd0,         110, 35, 88, 1'b0);
    random_phase(32'd3,         100, 35, 88, 1'b0);
    random_phase(32'd1,         110, 88, 35, 1'b0);
    random_phase(32'hFFFF_FFFF,  80, 88, 35, 1'b0);
    random_phase(32'd2,         110,  0,  0, 1'b1);
    random_phase(32'd300,        70,  0,  0, 1'b0);

    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (!hung) begin
      if (mismatches == 0 && pending_results.size() == 0) begin
        $display("RESULT: OK");
      end else begin
        $display("RESULT: ERROR");
      end
      $finish;
    end
  end

  // The receiver stalls at random; the decision is made at the rising edge.
  always @(posedge clk_i) begin
    out_stall_i <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // Outputs are sampled at the falling edge, where they are stable until the next
  // rising edge, so a beat seen here moves at that edge.
  always @(negedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data_o);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status ||
            out_data_o.picked_key !== want.picked_key ||
            out_data_o.picked_valid !== want.picked_valid ||
            out_data_o.entry_count !== want.entry_count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected %p, got %p", want, out_data_o);
          end
        end
      end
    end
  end

  // Watchdog: any beat on either channel restarts the count.
  always @(negedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= StuckLimit && !hung) begin
      hung = 1'b1;
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial stuck_cycles = 0;

endmodule
